// ===== sv/matrix_prime_row_sums_col_min_max_unit_assert.svh =====
// Assertion macros used by the back end (mprs_back) of the matrix prime unit.
`ifndef MATRIX_PRIME_ROW_SUMS_COL_MIN_MAX_UNIT_ASSERT_SVH
`define MATRIX_PRIME_ROW_SUMS_COL_MIN_MAX_UNIT_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define MP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mprs_pkg.sv =====
// ----------------------------------------------------------------------------
// mprs_pkg
// Shared types and constants of the matrix prime row sum unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mprs_pkg;
  localparam int MaxColumns = 32;
  localparam int ValueBits  = 32;
  localparam int SumBits    = 37;
  localparam int ColBits    = $clog2(MaxColumns);
  localparam int ColCntBits = $clog2(MaxColumns + 1);

  localparam logic [1:0] KindRowSum = 2'd0;
  localparam logic [1:0] KindMax    = 2'd1;
  localparam logic [1:0] KindColMin = 2'd2;

  localparam logic [0:0] RegRowCount = 1'b0;
  localparam logic [0:0] RegColCount = 1'b1;

  localparam logic signed [SumBits-1:0] SumMax = {1'b0, {(SumBits-1){1'b1}}};

  // classified element handed from front to back
  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic                        maybe_prime; // candidate for the trial loop
    logic                        sure_prime;  // 2 or 3
  } elem_t;

  typedef enum logic [2:0] {
    BkIdle, BkDiv, BkApply, BkRow, BkMax, BkCol
  } bk_state_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [15:0]         index;
    logic signed [SumBits-1:0] value;
    logic                last;
  } res_t;
endpackage
`default_nettype wire

// ===== sv/mprs_if.sv =====
// ----------------------------------------------------------------------------
// mprs_elem_if / mprs_res_if
// Valid/ready channels for elements and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface mprs_elem_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface mprs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] result_index;
  logic [36:0] result_value;
  logic        last_of_run;
  modport source (output valid, output result_kind, output result_index,
                  output result_value, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input result_index,
                  input result_value, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/matrix_prime_row_sums_col_min_max_unit.sv =====
// Elements that need no trial division go straight to the update; each
// trial divisor runs a 32-step remainder in the divider.
// The back end works on one element at a time and takes the next from the
// queue only in its idle state; a prime near 2^31 runs ~15.4k divisions.
// Reset: rst_ni asynchronous, active low; registers return to 1 row/1 column.
// ----------------------------------------------------------------------------
// matrix_prime_row_sums_col_min_max_unit
// Top level: configuration registers, front screener and back executor.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_prime_row_sums_col_min_max_unit import mprs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  mprs_elem_if.sink  in_if,
  mprs_res_if.source out_if
);
  logic [15:0] rows_q;
  logic [5:0]  cols_q;
  logic        qv, qpop;
  elem_t       qe;
  res_t        res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 16'd1; cols_q <= 6'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRowCount: rows_q <= cfg_data_i;
        RegColCount: cols_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  mprs_front u_front (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_value_i(in_if.element_value), .q_valid_o(qv), .q_pop_i(qpop),
    .q_elem_o(qe)
  );

  mprs_back u_back (
    .clk_i, .rst_ni, .row_count_i(rows_q), .col_count_i(cols_q),
    .q_valid_i(qv), .q_pop_o(qpop), .q_elem_i(qe),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.result_kind  = res.kind;
  assign out_if.result_index = res.index;
  assign out_if.result_value = res.value;
  assign out_if.last_of_run  = res.last;
endmodule
`default_nettype wire

// ===== sv/mprs_front.sv =====
// ----------------------------------------------------------------------------
// mprs_front
// Accepts elements, screens small values and multiples of 2 and 3, and
// queues them for the back end in a two-entry FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
module mprs_front import mprs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic [ValueBits-1:0] in_value_i,
  output logic       q_valid_o,
  input  wire logic  q_pop_i,
  output elem_t      q_elem_o
);
  elem_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic signed [ValueBits-1:0] v;
  logic [ValueBits-1:0] n;
  logic [ValueBits-1:0] m3;
  logic       push, pop;
  elem_t      cls;

  assign v = $signed(in_value_i);
  assign n = in_value_i;
  // n mod 3 == 0 via n*0xAAAAAAAB low word <= 0x55555555
  assign m3 = n * 32'hAAAAAAAB;

  always_comb begin
    cls.value       = v;
    cls.sure_prime  = (v == 2) || (v == 3);
    cls.maybe_prime = !cls.sure_prime && (v > 3) && n[0] &&
                      (m3 > 32'h55555555);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_elem_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/mprs_divider.sv =====
// ----------------------------------------------------------------------------
// mprs_divider
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mprs_divider import mprs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [ValueBits-1:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic      done_o,
  output logic      zero_o
);
  localparam int CntBits = $clog2(ValueBits + 1);
  logic [ValueBits-1:0] num_q;
  logic [16:0]          rem_q;
  logic [15:0]          den_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q, done_q;
  logic [16:0]          sh, df;

  assign sh = {rem_q[15:0], num_q[ValueBits-1]};
  assign df = sh - {1'b0, den_q};
  assign done_o = done_q;
  assign zero_o = (rem_q == 17'd0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i; den_q <= divisor_i; rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[ValueBits-2:0], 1'b0};
      rem_q <= df[16] ? sh : df;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= CntBits'(ValueBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0; done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/mprs_back.sv =====
// ----------------------------------------------------------------------------
// mprs_back
// Runs the trial division, updates sums and extrema, emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module mprs_back import mprs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic [15:0] row_count_i,
  input  wire logic [5:0]  col_count_i,
  input  wire logic  q_valid_i,
  output logic       q_pop_o,
  input  wire elem_t q_elem_i,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output res_t       res_o
);
  `include "matrix_prime_row_sums_col_min_max_unit_assert.svh"

  bk_state_e state_q, state_d;
  elem_t     el_q;
  logic [15:0] div_q;
  logic        odd_q;       // testing d+2
  logic        prime_q;
  logic signed [ValueBits-1:0] colmin_q [MaxColumns];
  logic signed [SumBits-1:0] sum_q;
  logic signed [ValueBits-1:0] max_q;
  logic [15:0] row_q;
  logic [ColBits-1:0] colp_q, ci_q;
  logic        ov_q;        // result register occupied
  res_t        out_q;
  logic        dgo_q, dgo_d;

  logic [15:0] rows;
  logic [ColCntBits-1:0] cols;
  logic [ColBits-1:0] col;
  logic        dstart, ddone, dzero;
  logic [15:0] dden;
  logic [32:0] dsq;
  logic        next_ok;     // (d+6)^2 <= n
  logic signed [SumBits:0] nsum;
  logic        last_col, last_row;
  logic        emit;

  assign rows = (row_count_i == 16'd0) ? 16'd1 : row_count_i;
  always_comb begin
    if (col_count_i == 6'd0) cols = ColCntBits'(1);
    else if ({1'b0, col_count_i} > 7'(MaxColumns)) cols = ColCntBits'(MaxColumns);
    else cols = ColCntBits'(col_count_i);
  end
  assign col = ({1'b0, colp_q} < cols) ? colp_q : ColBits'(cols - 1'b1);
  assign last_col = ({1'b0, colp_q} + 1'b1) >= cols;
  assign last_row = (row_q + 16'd1) >= rows;

  assign dden = odd_q ? div_q + 16'd2 : div_q;
  assign dsq  = div_q * div_q;
  assign next_ok = (dsq + 33'd12 * {17'd0, div_q} + 33'd36) <= {1'b0, el_q.value};

  mprs_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(el_q.value),
    .divisor_i(dden), .done_o(ddone), .zero_o(dzero)
  );

  assign nsum = {sum_q[SumBits-1], sum_q} + (SumBits+1)'(el_q.value);
  assign res_valid_o = ov_q;
  assign res_o = out_q;
  logic out_free;
  assign out_free = !ov_q || res_ready_i;
  assign emit = out_free &&
                (state_q == BkRow || state_q == BkMax || state_q == BkCol);

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    dgo_d   = 1'b0;
    unique case (state_q)
      BkIdle: if (q_valid_i) begin
        q_pop_o = 1'b1;
        // 25 > n needs no division
        if (q_elem_i.maybe_prime && q_elem_i.value >= 32'sd25) begin
          state_d = BkDiv;
          dgo_d   = 1'b1;
        end else begin
          state_d = BkApply;
        end
      end
      BkDiv: if (ddone) begin
        if (dzero || (odd_q && !next_ok)) state_d = BkApply;
        else dgo_d = 1'b1;
      end
      BkApply: if (out_free || !last_col) state_d = last_col ? BkRow : BkIdle;
      BkRow:  if (out_free) state_d = last_row ? BkMax : BkIdle;
      BkMax:  if (out_free) state_d = BkCol;
      BkCol:  if (out_free && ({1'b0, ci_q} + 1'b1 >= cols)) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // divider start pulse: on entering division or after a nonzero remainder with divisors left
  assign dstart = dgo_q;

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && q_valid_i) el_q <= q_elem_i;
  end

  // column minimum store
  always_ff @(posedge clk_i) begin
    if (state_q == BkApply && state_d != BkApply &&
        (row_q == 16'd0 || el_q.value < colmin_q[col]))
      colmin_q[col] <= el_q.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle; div_q <= 16'd5; odd_q <= 1'b0; prime_q <= 1'b0;
      sum_q <= '0; max_q <= {1'b1, {(ValueBits-1){1'b0}}}; row_q <= '0;
      colp_q <= '0; ci_q <= '0; ov_q <= 1'b0; dgo_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      dgo_q   <= dgo_d;
      ov_q    <= emit || (ov_q && !res_ready_i);
      unique case (state_q)
        BkIdle: if (q_valid_i) begin
          div_q <= 16'd5; odd_q <= 1'b0;
          prime_q <= q_elem_i.sure_prime || q_elem_i.maybe_prime;
        end
        BkDiv: if (ddone) begin
          if (dzero) prime_q <= 1'b0;
          else if (!odd_q) odd_q <= 1'b1;
          else if (next_ok) begin
            odd_q <= 1'b0; div_q <= div_q + 16'd6;
          end
        end
        BkApply: if (state_d != BkApply) begin
          if (el_q.value > max_q) max_q <= el_q.value;
          if (prime_q) sum_q <= (nsum > {SumMax[SumBits-1], SumMax}) ? SumMax
                                                              : nsum[SumBits-1:0];
          colp_q <= last_col ? '0 : colp_q + 1'b1;
        end
        BkRow: if (out_free) begin
          out_q <= '{kind: KindRowSum, index: row_q, value: sum_q, last: !last_row};
          sum_q <= '0;
          row_q <= last_row ? row_q : row_q + 16'd1;
        end
        BkMax: if (out_free) begin
          ci_q <= '0;
          out_q <= '{kind: KindMax, index: 16'd0,
                     value: SumBits'(max_q), last: 1'b0};
        end
        BkCol: if (out_free) begin
          out_q <= '{kind: KindColMin, index: 16'(ci_q),
                     value: SumBits'(colmin_q[ci_q]),
                     last: ({1'b0, ci_q} + 1'b1 >= cols)};
          ci_q <= ci_q + 1'b1;
          if ({1'b0, ci_q} + 1'b1 >= cols) begin
            row_q <= '0; sum_q <= '0;
            max_q <= {1'b1, {(ValueBits-1){1'b0}}};
          end
        end
        default: ;
      endcase
    end
  end

  `MP_ASSERT_NXT(a_res_hold, clk_i, rst_ni, ov_q && !res_ready_i, ov_q && $stable(out_q),
                 "result changed while stalled")
  `MP_ASSERT_IMP(a_div_idle, clk_i, rst_ni, ddone, state_q == BkDiv,
                 "divider finished outside trial state")
  `MP_ASSERT_IMP(a_no_pop, clk_i, rst_ni, q_pop_o, state_q == BkIdle,
                 "queue popped while busy")
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the matrix prime row sum unit. A driver feeds matrix
// elements from a queue, a predictor computes row prime sums, the frame
// maximum and the column minima, and a monitor compares each result request.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import mprs_pkg::*;

  localparam int unsigned WatchdogLimit = 3000000;
  localparam int unsigned DrainCycles   = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  mprs_elem_if elem_if ();
  mprs_res_if  res_if ();

  matrix_prime_row_sums_col_min_max_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (elem_if.sink),
    .out_if      (res_if.source)
  );

  // elements waiting to be offered, results still owed by the block
  logic [31:0] element_q[$];
  res_t        owed_results_q[$];

  // idle / stall rates in percent, set per phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // bumping this token asks the receiver for one long hold-off
  int unsigned hold_token;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned error_count;

  // predictor copy of registers and frame state
  logic [15:0]        row_count_reg;
  logic [5:0]         col_count_reg;
  logic signed [31:0] col_min[MaxColumns];
  longint             row_sum;
  logic signed [31:0] frame_max;
  int unsigned        row_pos;
  int unsigned        col_pos;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // 6k+-1 trial division, same divisor order as the hardware loop
  function automatic bit is_prime(logic signed [31:0] v);
    int unsigned n;
    longint unsigned d;
    if (v == 2 || v == 3) return 1'b1;
    if (v < 3) return 1'b0;
    n = v;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    for (d = 5; d * d <= n; d += 6) begin
      if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void owe_result(logic [1:0] kind, int unsigned idx,
                                     logic signed [36:0] value);
    res_t r;
    r.kind  = kind;
    r.index = idx[15:0];
    r.value = value;
    r.last  = 1'b0;
    owed_results_q.push_back(r);
  endfunction

  // frame bookkeeping for one accepted element
  function automatic void predict_element(logic signed [31:0] x);
    int unsigned rows, cols, col;
    rows = (row_count_reg == 0) ? 1 : row_count_reg;
    cols = (col_count_reg == 0) ? 1 : col_count_reg;
    if (cols > MaxColumns) cols = MaxColumns;
    col = (col_pos < cols) ? col_pos : cols - 1;
    if (row_pos == 0 || x < col_min[col]) col_min[col] = x;
    if (x > frame_max) frame_max = x;
    if (is_prime(x)) begin
      row_sum += x;
      if (row_sum > longint'(SumMax)) row_sum = SumMax;
    end
    if (col_pos + 1 < cols) begin
      col_pos++;
      return;
    end
    owe_result(KindRowSum, row_pos, row_sum[36:0]);
    row_sum = 0;
    col_pos = 0;
    if (row_pos + 1 < rows) begin
      row_pos++;
    end else begin
      owe_result(KindMax, 0, frame_max);
      for (int j = 0; j < cols; j++) owe_result(KindColMin, j, col_min[j]);
      row_sum   = 0;
      frame_max = 32'sh8000_0000;
      row_pos   = 0;
      col_pos   = 0;
    end
    owed_results_q[owed_results_q.size() - 1].last = 1'b1;
  endfunction

  // driver: one request per accept, random gaps per phase
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (elem_if.valid && elem_if.ready) predict_element(elem_if.element_value);
      if (!elem_if.valid || elem_if.ready) begin
        if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          elem_if.valid         <= 1'b1;
          elem_if.element_value <= element_q.pop_front();
        end else begin
          elem_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result request with the oldest owed result
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (owed_results_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d index %0d value %0d", $time,
                   res_if.result_kind, res_if.result_index,
                   $signed(res_if.result_value));
          error_count++;
        end else begin
          e = owed_results_q.pop_front();
          if (res_if.result_kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind,
                     res_if.result_kind);
            error_count++;
          end
          if (res_if.result_index !== e.index) begin
            $display("%0t: index expected %0d actual %0d", $time, e.index,
                     res_if.result_index);
            error_count++;
          end
          if (res_if.result_value !== e.value) begin
            $display("%0t: value expected %0d actual %0d", $time, e.value,
                     $signed(res_if.result_value));
            error_count++;
          end
          if (res_if.last_of_run !== e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last,
                     res_if.last_of_run);
            error_count++;
          end
        end
      end
      // long hold-off counted here; otherwise random stalls
      if (hold_token != hold_seen) begin
        hold_seen    <= hold_token;
        hold_left    <= 4000;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((elem_if.valid && elem_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegRowCount) row_count_reg = data;
    else col_count_reg = data[5:0];
  endtask

  // wait until all elements are taken and all results returned, then let
  // the block finish any element that owes no result
  task automatic drain_block();
    do begin
      @(posedge clk_i);
      #1;
    end while (element_q.size() > 0 || elem_if.valid || owed_results_q.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly cheap values; negatives with random low bits exercise every bit
  function automatic logic [31:0] random_element();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(200);
    if (pick < 75) return $urandom_range(2000);
    if (pick < 85) return $urandom_range(100000);
    return $urandom | 32'h8000_0000;
  endfunction

  // whole frames at the counts the block will actually use
  task automatic run_frames(int unsigned rows, int unsigned cols, int unsigned frames);
    int unsigned eff_rows, eff_cols;
    eff_rows = (rows[15:0] == 0) ? 1 : rows[15:0];
    eff_cols = (cols[5:0] == 0) ? 1 : cols[5:0];
    if (eff_cols > MaxColumns) eff_cols = MaxColumns;
    write_reg(RegRowCount, rows[15:0]);
    write_reg(RegColCount, cols[15:0]);
    repeat (frames * eff_rows * eff_cols) element_q.push_back(random_element());
    drain_block();
  endtask

  initial begin
    logic [31:0] corner_values[$];
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = RegRowCount;
    cfg_data_i            = '0;
    elem_if.valid         = 1'b0;
    elem_if.element_value = '0;
    res_if.ready          = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_token            = 0;
    hold_seen             = 0;
    hold_left             = 0;
    idle_cycles           = 0;
    error_count           = 0;
    row_count_reg         = 1;
    col_count_reg         = 1;
    row_sum               = 0;
    frame_max             = 32'sh8000_0000;
    row_pos               = 0;
    col_pos               = 0;
    foreach (col_min[i]) col_min[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 frames from reset: small primes, screened values, square of a
    // divisor, both extremes (the top value is prime and runs the full loop)
    corner_values = '{32'd2, 32'd3, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd4, 32'd9,
                      32'd25, 32'd35, 32'd49, 32'd121, 32'd5, 32'd7, 32'd97,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'd65521};
    foreach (corner_values[i]) element_q.push_back(corner_values[i]);
    drain_block();

    // zero counts act as one; an oversized column count acts as the maximum
    run_frames(0, 0, 2);
    run_frames(1, 63, 1);

    // no idling; long receiver hold-off fills the block and stalls input
    hold_token++;
    run_frames(1, 1, 8);
    run_frames(3, 5, 1);

    send_idle_pct = 82;
    run_frames(2, 4, 3);
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    run_frames(4, 3, 1);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_frames(1, 7, 2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // mid-frame writes: a huge row count cut short ends the frame early
    write_reg(RegRowCount, 16'hFFFF);
    write_reg(RegColCount, 16'd1);
    repeat (5) element_q.push_back(random_element() & 32'h0000_00FF);
    drain_block();
    write_reg(RegRowCount, 16'd3);
    element_q.push_back(32'd13);
    drain_block();

    // shrinking the column count in mid-row ends the row at the next element
    write_reg(RegRowCount, 16'd2);
    write_reg(RegColCount, 16'd4);
    repeat (5) element_q.push_back(random_element() & 32'h0000_00FF);
    drain_block();
    write_reg(RegColCount, 16'd2);
    element_q.push_back(32'd11);
    drain_block();

    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_frames(2, 2, 4);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== matrix_prime_row_sums_col_min_max_unit.f =====
+incdir+sv
sv/mprs_pkg.sv
sv/mprs_if.sv
sv/mprs_front.sv
sv/mprs_divider.sv
sv/mprs_back.sv
sv/matrix_prime_row_sums_col_min_max_unit.sv
tb/testbench.sv
